>>> hdl/gtel_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtel_pkg
// Shared request/response types and function codes for the event latch.
// ----------------------------------------------------------------------------
package gtel_pkg;

    localparam int GEN_IN_W = 32;
    localparam int FUNC_W   = 3;
    localparam int EVT_W    = 2;

    localparam logic [FUNC_W-1:0] FUNC_BEGIN   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_RETIRE  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMMIT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_PUBLISH = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CONSUME = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd5;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [GEN_IN_W-1:0] generation;
        logic [EVT_W-1:0]    event_in;
    } t_req;

    typedef struct packed {
        logic                ok;
        logic [EVT_W-1:0]    event_out;
        logic [GEN_IN_W-1:0] active_generation;
    } t_rsp;

endpackage

>>> hdl/gtel_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtel_exec
// Single-pass request evaluation: slot matches, next table state, response.
// ----------------------------------------------------------------------------
module gtel_exec #(
    parameter int SLOT_COUNT = 2,
    parameter int GEN_WIDTH  = 32
) (
    input  gtel_pkg::t_req                 i_req,
    input  logic [GEN_WIDTH-1:0]           i_slot_gen [SLOT_COUNT],
    input  logic [gtel_pkg::EVT_W-1:0]     i_slot_evt [SLOT_COUNT],
    input  logic [GEN_WIDTH-1:0]           i_active,
    output logic [GEN_WIDTH-1:0]           o_slot_gen [SLOT_COUNT],
    output logic [gtel_pkg::EVT_W-1:0]     o_slot_evt [SLOT_COUNT],
    output logic [GEN_WIDTH-1:0]           o_active,
    output gtel_pkg::t_rsp                 o_rsp
);
    import gtel_pkg::*;

    localparam int EXT_W = (GEN_WIDTH > GEN_IN_W) ? GEN_WIDTH : GEN_IN_W;

    logic [EXT_W-1:0]     gen_x;
    logic [EXT_W-1:0]     act_x;
    logic [GEN_WIDTH-1:0] gen_s;
    logic                 fits;
    logic                 gen_nz;
    logic                 gen_ok;
    logic                 present;
    logic                 any_empty;
    logic                 is_active;
    logic [SLOT_COUNT-1:0] hit;
    logic [SLOT_COUNT-1:0] prior_hit;
    logic [SLOT_COUNT-1:0] first_empty;
    logic [SLOT_COUNT-1:0] first_hit;
    logic [SLOT_COUNT-1:0] first_pend;
    logic                 ok;
    logic [EVT_W-1:0]     taken;

    assign gen_x     = EXT_W'(i_req.generation);
    assign gen_s     = gen_x[GEN_WIDTH-1:0];
    assign fits      = (gen_x >> GEN_WIDTH) == '0;
    assign gen_nz    = i_req.generation != '0;
    assign gen_ok    = gen_nz && fits;
    assign present   = |hit;
    assign any_empty = |first_empty;
    assign is_active = gen_ok && (i_active == gen_s);

    // match vectors and first-slot priority picks
    always_comb begin
        logic seen_e;
        logic seen_h;
        logic seen_p;
        seen_e = 1'b0;
        seen_h = 1'b0;
        seen_p = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            hit[i]       = gen_ok && (i_slot_gen[i] == gen_s);
            prior_hit[i] = i_slot_gen[i] == i_active;
            first_empty[i] = !seen_e && (i_slot_gen[i] == '0);
            seen_e = seen_e || (i_slot_gen[i] == '0);
            first_hit[i] = !seen_h && hit[i];
            seen_h = seen_h || hit[i];
            first_pend[i] = !seen_p && hit[i] && (i_slot_evt[i] != '0);
            seen_p = seen_p || (hit[i] && (i_slot_evt[i] != '0));
        end
    end

    always_comb begin
        o_slot_gen = i_slot_gen;
        o_slot_evt = i_slot_evt;
        o_active   = i_active;
        ok         = 1'b0;
        taken      = '0;
        case (i_req.func)
            FUNC_BEGIN: begin
                if (gen_ok && !present && any_empty) begin
                    ok = 1'b1;
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (first_empty[i]) begin
                            o_slot_gen[i] = gen_s;
                            o_slot_evt[i] = '0;
                        end
                    end
                end
            end
            FUNC_RETIRE: begin
                ok = 1'b1;
                if (is_active) begin
                    o_active = '0;
                end
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (hit[i]) begin
                        o_slot_gen[i] = '0;
                        o_slot_evt[i] = '0;
                    end
                end
            end
            FUNC_COMMIT: begin
                if (present) begin
                    ok       = 1'b1;
                    o_active = gen_s;
                    // the prior generation is dropped unless it is the same one
                    if (i_active != '0 && i_active != gen_s) begin
                        for (int i = 0; i < SLOT_COUNT; i++) begin
                            if (prior_hit[i]) begin
                                o_slot_gen[i] = '0;
                                o_slot_evt[i] = '0;
                            end
                        end
                    end
                end
            end
            FUNC_PUBLISH: begin
                if (gen_ok && i_req.event_in != '0) begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (first_hit[i] && i_slot_evt[i] == '0) begin
                            o_slot_evt[i] = i_req.event_in;
                            ok = 1'b1;
                        end
                    end
                end
            end
            FUNC_CONSUME: begin
                if (is_active) begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (first_pend[i]) begin
                            taken         = i_slot_evt[i];
                            o_slot_evt[i] = '0;
                            ok            = 1'b1;
                        end
                    end
                end
            end
            FUNC_READ: begin
                ok = 1'b1;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    assign act_x                   = EXT_W'(o_active);
    assign o_rsp.ok                = ok;
    assign o_rsp.event_out         = taken;
    assign o_rsp.active_generation = act_x[GEN_IN_W-1:0];

endmodule

>>> hdl/gtel_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtel_state
// Slot table and active-generation registers, loaded once per request.
// ----------------------------------------------------------------------------
module gtel_state #(
    parameter int SLOT_COUNT = 2,
    parameter int GEN_WIDTH  = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic [GEN_WIDTH-1:0]       i_slot_gen [SLOT_COUNT],
    input  logic [gtel_pkg::EVT_W-1:0] i_slot_evt [SLOT_COUNT],
    input  logic [GEN_WIDTH-1:0]       i_active,
    output logic [GEN_WIDTH-1:0]       o_slot_gen [SLOT_COUNT],
    output logic [gtel_pkg::EVT_W-1:0] o_slot_evt [SLOT_COUNT],
    output logic [GEN_WIDTH-1:0]       o_active
);
    import gtel_pkg::*;

    logic [GEN_WIDTH-1:0] r_slot_gen [SLOT_COUNT];
    logic [EVT_W-1:0]     r_slot_evt [SLOT_COUNT];
    logic [GEN_WIDTH-1:0] r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slot_gen[i] <= '0;
                r_slot_evt[i] <= '0;
            end
            r_active <= '0;
        end else if (i_en) begin
            r_slot_gen <= i_slot_gen;
            r_slot_evt <= i_slot_evt;
            r_active   <= i_active;
        end
    end

    assign o_slot_gen = r_slot_gen;
    assign o_slot_evt = r_slot_evt;
    assign o_active   = r_active;

endmodule

>>> hdl/generation_tagged_event_latch_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generation_tagged_event_latch_top
// Generation-tagged event mailboxes with an active-generation register.
// ----------------------------------------------------------------------------
// Usage: each request (func, generation, event_in) yields exactly one
// response (ok, event_out, active_generation). A request is captured in an
// input register, evaluated against the slot table in one pass, and the
// response lands in an output register while the table updates on the same
// edge. Throughput is one request per cycle while the receiver keeps up;
// a stalled output register holds the input register. The rate is set by
// the single table read-modify-write per cycle, which lets the next request
// see the updated slots with no forwarding. The input stage keeps taking
// requests while a response waits, as long as the output register can drain.
// Zero generations are never stored; generations above GEN_WIDTH bits are
// rejected by begin and publish and match nothing elsewhere.
// ----------------------------------------------------------------------------
module generation_tagged_event_latch_top #(
    parameter int SLOT_COUNT = 2,
    parameter int GEN_WIDTH  = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  gtel_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output gtel_pkg::t_rsp o_out_data
);
    import gtel_pkg::*;

    // input request register
    logic r_in_vld;
    logic n_in_vld;
    t_req r_in;

    // response register
    logic r_out_vld;
    logic n_out_vld;
    t_rsp r_out;

    // request in the input register retires into the response register
    logic advance;

    logic [GEN_WIDTH-1:0] cur_gen [SLOT_COUNT];
    logic [EVT_W-1:0]     cur_evt [SLOT_COUNT];
    logic [GEN_WIDTH-1:0] cur_act;
    logic [GEN_WIDTH-1:0] nxt_gen [SLOT_COUNT];
    logic [EVT_W-1:0]     nxt_evt [SLOT_COUNT];
    logic [GEN_WIDTH-1:0] nxt_act;
    t_rsp                 rsp;

    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;

    assign n_in_vld  = (i_in_valid && o_in_ready) ? 1'b1 : (advance ? 1'b0 : r_in_vld);
    assign n_out_vld = advance ? 1'b1 : ((r_out_vld && i_out_ready) ? 1'b0 : r_out_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= rsp;
        end
    end

    gtel_exec #(
        .SLOT_COUNT (SLOT_COUNT),
        .GEN_WIDTH  (GEN_WIDTH)
    ) u_exec (
        .i_req      (r_in),
        .i_slot_gen (cur_gen),
        .i_slot_evt (cur_evt),
        .i_active   (cur_act),
        .o_slot_gen (nxt_gen),
        .o_slot_evt (nxt_evt),
        .o_active   (nxt_act),
        .o_rsp      (rsp)
    );

    // table commits only when the request actually moves to the response
    gtel_state #(
        .SLOT_COUNT (SLOT_COUNT),
        .GEN_WIDTH  (GEN_WIDTH)
    ) u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (advance),
        .i_slot_gen (nxt_gen),
        .i_slot_evt (nxt_evt),
        .i_active   (nxt_act),
        .o_slot_gen (cur_gen),
        .o_slot_evt (cur_evt),
        .o_active   (cur_act)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

>>> sim/generation_tagged_event_latch_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generation_tagged_event_latch_top_tb
// Self-checking bench for the generation-tagged event latch. Requests go
// through a bursty valid/ready sender, and responses through a receiver that
// stalls in changing patterns. A behavioral copy of the slot table predicts
// every response, and the responses are checked in order, field by field.
// ----------------------------------------------------------------------------
module generation_tagged_event_latch_top_tb;

    import gtel_pkg::*;

    // Table geometry, matching the instance defaults.
    localparam int SLOTS      = 2;
    localparam int TBL_GEN_W  = 32;
    localparam int POOL_SIZE  = 4;
    localparam int TAIL_CYCLES = 12;
    localparam int REPORT_MAX = 10;

    // Function codes the block does not define; they must act as no-ops.
    localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_LIGHT,
        RX_PERIODIC
    } rx_mode_e;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_ready = 1'b0;
    t_req i_in_data   = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_rsp o_out_data;

    generation_tagged_event_latch_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow copy of the block state
    // ------------------------------------------------------------------
    logic [GEN_IN_W-1:0] tbl_gen [SLOTS];
    logic [EVT_W-1:0]    tbl_evt [SLOTS];
    logic [GEN_IN_W-1:0] act_gen;

    // Responses still owed by the block, oldest first.
    t_rsp pending_rsp [$];

    int items_sent;
    int responses_checked;
    int mismatch_count;
    int ok_seen;
    int events_taken;

    // Sender pacing.
    bit sender_steady;
    int burst_left;

    // Generations the random sequences keep coming back to, so that
    // begin/publish/commit/consume actually hit the same slots.
    logic [GEN_IN_W-1:0] gen_pool [POOL_SIZE];

    rx_mode_e    rx_mode = RX_ALWAYS;
    logic [31:0] rx_cycle = '0;

    function automatic bit gen_in_table(input logic [GEN_IN_W-1:0] gen);
        for (int i = 0; i < SLOTS; i++)
            if (tbl_gen[i] == gen)
                return 1'b1;
        return 1'b0;
    endfunction

    // Clears the active register if it names gen, and empties gen's slots.
    function automatic void drop_generation(input logic [GEN_IN_W-1:0] gen);
        if (gen == '0)
            return;
        if (act_gen == gen)
            act_gen = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (tbl_gen[i] == gen) begin
                tbl_gen[i] = '0;
                tbl_evt[i] = '0;
            end
        end
    endfunction

    // Applies one request to the shadow table and returns its response.
    function automatic t_rsp predict_response(input t_req req);
        t_rsp                rsp;
        logic                gen_ok;
        logic                found;
        logic [GEN_IN_W-1:0] prior;
        rsp    = '0;
        found  = 1'b0;
        // Nonzero and within the table's generation width.
        gen_ok = (req.generation != '0) &&
                 ((64'(req.generation) >> TBL_GEN_W) == 64'd0);
        case (req.func)
            FUNC_BEGIN: begin
                if (gen_ok && !gen_in_table(req.generation)) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!found && tbl_gen[i] == '0) begin
                            tbl_gen[i] = req.generation;
                            tbl_evt[i] = '0;
                            rsp.ok     = 1'b1;
                            found      = 1'b1;
                        end
                    end
                end
            end
            FUNC_RETIRE: begin
                drop_generation(req.generation);
                rsp.ok = 1'b1;
            end
            FUNC_COMMIT: begin
                if (req.generation != '0 && gen_in_table(req.generation)) begin
                    prior   = act_gen;
                    act_gen = req.generation;
                    if (prior != '0 && prior != req.generation)
                        drop_generation(prior);
                    rsp.ok = 1'b1;
                end
            end
            FUNC_PUBLISH: begin
                // Only the first slot holding the generation is considered.
                if (gen_ok && req.event_in != '0) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!found && tbl_gen[i] == req.generation) begin
                            found = 1'b1;
                            if (tbl_evt[i] == '0) begin
                                tbl_evt[i] = req.event_in;
                                rsp.ok     = 1'b1;
                            end
                        end
                    end
                end
            end
            FUNC_CONSUME: begin
                if (req.generation != '0 && act_gen == req.generation) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!found && tbl_gen[i] == req.generation &&
                            tbl_evt[i] != '0) begin
                            rsp.event_out = tbl_evt[i];
                            tbl_evt[i]    = '0;
                            rsp.ok        = 1'b1;
                            found         = 1'b1;
                        end
                    end
                end
            end
            FUNC_READ: begin
                rsp.ok = 1'b1;
            end
            default: begin
            end
        endcase
        rsp.active_generation = act_gen;
        return rsp;
    endfunction

    // Returns 1 while detailed reports are still wanted.
    function automatic bit note_failure();
        mismatch_count++;
        return mismatch_count <= REPORT_MAX;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Sends one request, idling before it when a burst has run out, and
    // returns at the edge that accepts it with valid still high.
    task automatic send_request(input logic [FUNC_W-1:0]   func,
                                input logic [GEN_IN_W-1:0] gen,
                                input logic [EVT_W-1:0]    ev);
        t_req req;
        int   gap;
        req.func       = func;
        req.generation = gen;
        req.event_in   = ev;
        if (!sender_steady) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 24);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left--;
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        // Accepted on this edge: the shadow table moves on now.
        pending_rsp.push_back(predict_response(req));
        items_sent++;
    endtask

    task automatic wait_until_drained();
        i_in_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [GEN_IN_W-1:0] fresh_generation();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0001;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [EVT_W-1:0] publish_event();
        // Mostly real events, now and then the rejected empty code.
        if ($urandom_range(0, 7) == 0)
            return '0;
        return EVT_W'($urandom_range(1, 3));
    endfunction

    // One well-formed life of a generation: reserve, publish, commit,
    // consume, sometimes retire. Random content throughout.
    task automatic run_lifecycle_sequence();
        logic [GEN_IN_W-1:0] g;
        int                  idx;
        int                  n;
        idx = $urandom_range(0, POOL_SIZE - 1);
        if ($urandom_range(0, 2) == 0)
            gen_pool[idx] = fresh_generation();
        g = gen_pool[idx];
        if ($urandom_range(0, 3) == 0)
            send_request(FUNC_RETIRE, gen_pool[$urandom_range(0, POOL_SIZE - 1)],
                         EVT_W'($urandom_range(0, 3)));
        send_request(FUNC_BEGIN, g, EVT_W'($urandom_range(0, 3)));
        n = $urandom_range(0, 3);
        repeat (n) send_request(FUNC_PUBLISH, g, publish_event());
        if ($urandom_range(0, 3) != 0)
            send_request(FUNC_COMMIT, g, EVT_W'($urandom_range(0, 3)));
        n = $urandom_range(0, 4);
        repeat (n) begin
            send_request(FUNC_CONSUME, g, EVT_W'($urandom_range(0, 3)));
            if ($urandom_range(0, 1) == 0)
                send_request(FUNC_PUBLISH, g, publish_event());
        end
        if ($urandom_range(0, 4) == 0)
            send_request(FUNC_READ, $urandom, EVT_W'($urandom_range(0, 3)));
        if ($urandom_range(0, 5) == 0)
            send_request(FUNC_RETIRE, g, EVT_W'($urandom_range(0, 3)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Zero generations, full table, duplicates, occupied and empty
    // mailboxes, inactive consume, recommit of the active generation,
    // commit that retires the prior one, and the spare function codes.
    task automatic test_directed_corners();
        send_request(FUNC_READ,    32'h0000_0000, 2'd0);
        send_request(FUNC_BEGIN,   32'h0000_0000, 2'd0);
        send_request(FUNC_COMMIT,  32'h0000_0000, 2'd0);
        send_request(FUNC_PUBLISH, 32'h0000_0000, 2'd1);
        send_request(FUNC_CONSUME, 32'h0000_0000, 2'd0);
        send_request(FUNC_RETIRE,  32'h0000_0000, 2'd0);
        send_request(FUNC_BEGIN,   32'hFFFF_FFFF, 2'd0);
        send_request(FUNC_BEGIN,   32'hFFFF_FFFF, 2'd3);   // duplicate
        send_request(FUNC_BEGIN,   32'h0000_0001, 2'd0);
        send_request(FUNC_BEGIN,   32'h0000_0002, 2'd0);   // table full
        send_request(FUNC_PUBLISH, 32'h0000_0001, 2'd0);   // empty event
        send_request(FUNC_PUBLISH, 32'h0000_0001, 2'd3);
        send_request(FUNC_PUBLISH, 32'h0000_0001, 2'd2);   // mailbox busy
        send_request(FUNC_PUBLISH, 32'h0000_0005, 2'd1);   // not present
        send_request(FUNC_CONSUME, 32'h0000_0001, 2'd0);   // not active
        send_request(FUNC_COMMIT,  32'h0000_0007, 2'd0);   // not present
        send_request(FUNC_COMMIT,  32'h0000_0001, 2'd0);
        send_request(FUNC_COMMIT,  32'h0000_0001, 2'd0);   // already active
        send_request(FUNC_CONSUME, 32'h0000_0001, 2'd0);
        send_request(FUNC_CONSUME, 32'h0000_0001, 2'd0);   // nothing pending
        send_request(FUNC_PUBLISH, 32'hFFFF_FFFF, 2'd1);
        send_request(FUNC_COMMIT,  32'hFFFF_FFFF, 2'd0);   // retires prior
        send_request(FUNC_SPARE_6, 32'hFFFF_FFFF, 2'd3);
        send_request(FUNC_SPARE_7, 32'hFFFF_FFFF, 2'd3);
        send_request(FUNC_CONSUME, 32'hFFFF_FFFF, 2'd0);
        send_request(FUNC_RETIRE,  32'hFFFF_FFFF, 2'd0);
        send_request(FUNC_READ,    32'hFFFF_FFFF, 2'd0);
    endtask

    task automatic test_lifecycle_random(input int count);
        int start;
        start = items_sent;
        while (items_sent - start < count)
            run_lifecycle_sequence();
    endtask

    // Stops feeding until the block has answered everything, then resumes
    // with a gap-free stream from an empty pipeline.
    task automatic test_drain_pause();
        repeat (3) run_lifecycle_sequence();
        wait_until_drained();
        sender_steady = 1'b1;
        test_lifecycle_random(40);
        sender_steady = 1'b0;
    endtask

    // Any function code, any generation, any event code.
    task automatic test_noise(input int count);
        logic [GEN_IN_W-1:0] g;
        repeat (count) begin
            case ($urandom_range(0, 3))
                0:       g = '0;
                1:       g = $urandom;
                default: g = gen_pool[$urandom_range(0, POOL_SIZE - 1)];
            endcase
            send_request(FUNC_W'($urandom_range(0, 7)), g,
                         EVT_W'($urandom_range(0, 3)));
        end
    endtask

    task automatic test_steady_stream(input int count);
        sender_steady = 1'b1;
        test_lifecycle_random(count);
        sender_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------
    // Drives the receiver's ready, redrawing the stall pattern at random.
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 96 == 0)
            rx_mode <= rx_mode_e'($urandom_range(0, 3));
        case (rx_mode)
            RX_ALWAYS:   i_out_ready <= 1'b1;
            RX_COIN:     i_out_ready <= 1'($urandom_range(0, 1));
            RX_LIGHT:    i_out_ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: i_out_ready <= (rx_cycle[2:0] >= 3'd3);
            default:     i_out_ready <= 1'b1;
        endcase
    end

    // Compares every accepted response with the oldest prediction.
    t_rsp want_rsp;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_rsp.size() == 0) begin
                if (note_failure())
                    $display("%0t: response with none outstanding: ok=%0b ev=%0d act=%h",
                             $realtime, o_out_data.ok, o_out_data.event_out,
                             o_out_data.active_generation);
            end else begin
                want_rsp = pending_rsp.pop_front();
                responses_checked++;
                if (want_rsp.ok) ok_seen++;
                if (want_rsp.event_out != '0) events_taken++;
                if (o_out_data.ok !== want_rsp.ok ||
                    o_out_data.event_out !== want_rsp.event_out ||
                    o_out_data.active_generation !== want_rsp.active_generation) begin
                    if (note_failure())
                        $display("%0t: response %0d: expected ok=%0b ev=%0d act=%h, got ok=%0b ev=%0d act=%h",
                                 $realtime, responses_checked, want_rsp.ok,
                                 want_rsp.event_out, want_rsp.active_generation,
                                 o_out_data.ok, o_out_data.event_out,
                                 o_out_data.active_generation);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tbl_gen[i] = '0;
            tbl_evt[i] = '0;
        end
        act_gen           = '0;
        items_sent        = 0;
        responses_checked = 0;
        mismatch_count    = 0;
        ok_seen           = 0;
        events_taken      = 0;
        sender_steady     = 1'b0;
        burst_left        = 0;
        for (int i = 0; i < POOL_SIZE; i++)
            gen_pool[i] = fresh_generation();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        test_lifecycle_random(500);
        test_drain_pause();
        test_noise(325);
        test_lifecycle_random(450);
        test_steady_stream(100);

        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests through begin/publish/commit/consume/retire/read and spare codes,",
                 items_sent);
        $display("checked %0d responses (%0d ok, %0d events taken), %0d mismatches.",
                 responses_checked, ok_seen, events_taken, mismatch_count);
        if (mismatch_count == 0 && pending_rsp.size() == 0)
            $display("generation_tagged_event_latch_top_tb: clean");
        else
            $display("generation_tagged_event_latch_top_tb: errors");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("generation_tagged_event_latch_top_tb: errors");
        $finish;
    end

endmodule
